[src/two_edge_connected_component_label_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the controller of the bridge-free component labeller
// ---------------------------------------------------------------------------
`ifndef TWO_EDGE_CONNECTED_COMPONENT_LABEL_TOP_MACROS_SVH
`define TWO_EDGE_CONNECTED_COMPONENT_LABEL_TOP_MACROS_SVH

// same-cycle implication
`define TECC_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tecc assertion failed");

// next-cycle implication
`define TECC_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tecc assertion failed");

`endif

[src/tecc_pkg.sv]
// ---------------------------------------------------------------------------
// tecc_pkg
// Shared types and constants of the bridge-free component labeller.
// ---------------------------------------------------------------------------
package tecc_pkg;

   localparam int DEF_MAX_NODES = 1024;
   localparam int DEF_MAX_EDGES = 2048;
   localparam int FIELD_W       = 11;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_RUN   = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef struct packed {
      logic               valid;
      logic [FIELD_W-1:0] answer;
      logic               overflow;
   } rsp_load_type;

endpackage

[src/two_edge_connected_component_label_top.sv]
// Add edge: two arc appends of read, write and link; a rejected edge is dropped while idle.
// Run: clears discovery times and labels of nodes 0 to MAX_NODES, then walks arcs and nodes.
// Query: answered through the label store read; clear graph: empties lists of nodes 0 to MAX_NODES.
// One request at a time; the result register frees the core while a response waits.
// Reset (synchronous): empties arc lists and zeroes labels of nodes 0 to MAX_NODES, stalled.
// ---------------------------------------------------------------------------
// two_edge_connected_component_label_top
// Bridge-free component labeller: edge loading, Tarjan search, label queries, graph clears.
// ---------------------------------------------------------------------------
module two_edge_connected_component_label_top
   import tecc_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [FIELD_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [FIELD_W-1:0] req_end_a,
   input  logic [FIELD_W-1:0] req_end_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FIELD_W-1:0] rsp_answer,
   output logic               rsp_overflow
);

   localparam int NW = $clog2(MAX_NODES + 1);

   logic [FIELD_W-1:0] node_count_ff;
   logic [31:0]        nc32;
   logic [NW-1:0]      eff_nodes;
   logic               rsp_valid_ff;
   logic [FIELD_W-1:0] rsp_answer_ff;
   logic               rsp_overflow_ff;
   logic               rsp_free;
   rsp_load_type       rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= FIELD_W'(1);
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // clamp to 1..MAX_NODES
   assign nc32      = 32'(node_count_ff);
   assign eff_nodes = (nc32 == 0) ? NW'(1) :
                      (nc32 > 32'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(nc32);

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load.valid) begin
         rsp_answer_ff   <= rsp_load.answer;
         rsp_overflow_ff <= rsp_load.overflow;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_answer   = rsp_answer_ff;
   assign rsp_overflow = rsp_overflow_ff;

   tecc_ctrl #(
      .MAX_NODES(MAX_NODES),
      .MAX_EDGES(MAX_EDGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_action(req_action),
      .req_end_a (req_end_a),
      .req_end_b (req_end_b),
      .eff_nodes (eff_nodes),
      .rsp_free  (rsp_free),
      .rsp_load  (rsp_load)
   );

endmodule

[src/tecc_ram.sv]
// ---------------------------------------------------------------------------
// tecc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tecc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/tecc_ctrl.sv]
// ---------------------------------------------------------------------------
// tecc_ctrl
// Edge loader, iterative Tarjan search and query sequencer over the stores.
// ---------------------------------------------------------------------------
`include "two_edge_connected_component_label_top_macros.svh"

module tecc_ctrl
   import tecc_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int MAX_EDGES = DEF_MAX_EDGES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_action,
   input  logic [FIELD_W-1:0]               req_end_a,
   input  logic [FIELD_W-1:0]               req_end_b,
   input  logic [$clog2(MAX_NODES+1)-1:0]   eff_nodes,
   input  logic                             rsp_free,
   output rsp_load_type                     rsp_load
);

   localparam int NW      = $clog2(MAX_NODES + 1);
   localparam int ARC_CAP = 2 * MAX_EDGES;
   localparam int AW      = $clog2(ARC_CAP + 1);
   localparam int ARW     = $clog2(ARC_CAP);
   localparam int STW     = $clog2(MAX_NODES);
   localparam logic [AW-1:0] NO_ARC = AW'(ARC_CAP);
   localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES);

   typedef struct packed {
      logic [NW-1:0] node;
      logic [NW-1:0] parent;
      logic [AW-1:0] arc;
      logic [NW-1:0] disc;
      logic [NW-1:0] low;
   } frame_type;

   localparam int FRW = $bits(frame_type);

   typedef enum logic [18:0] {
      S_IDLE     = 19'(1) << 0,
      S_LCLR     = 19'(1) << 1,
      S_ADD_RD   = 19'(1) << 2,
      S_ADD_WR   = 19'(1) << 3,
      S_ADD_LINK = 19'(1) << 4,
      S_NCLR     = 19'(1) << 5,
      S_ROOT     = 19'(1) << 6,
      S_ARC      = 19'(1) << 7,
      S_ARC_W    = 19'(1) << 8,
      S_ARC_N    = 19'(1) << 9,
      S_PUSH_H   = 19'(1) << 10,
      S_FIN      = 19'(1) << 11,
      S_POP_RD   = 19'(1) << 12,
      S_POP_W    = 19'(1) << 13,
      S_RET      = 19'(1) << 14,
      S_RET_W    = 19'(1) << 15,
      S_QRY      = 19'(1) << 16,
      S_QRY_W    = 19'(1) << 17,
      S_RESP     = 19'(1) << 18
   } state_type;

   state_type          state_ff, state_in;
   logic [NW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      tot_ff, tot_in;
   logic               ovf_ff, ovf_in;
   logic               boot_ff, boot_in;
   logic [NW-1:0]      from_ff, from_in, to_ff, to_in;
   logic               second_ff, second_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic               link_ff, link_in;
   logic [NW-1:0]      x_ff, x_in, par_ff, par_in;
   logic [AW-1:0]      arc_ff, arc_in;
   logic [NW-1:0]      xdisc_ff, xdisc_in, xlow_ff, xlow_in;
   logic [NW-1:0]      nt_ff, nt_in, np_ff, np_in;
   logic [NW-1:0]      t_ff, t_in;
   logic [NW-1:0]      sp_ff, sp_in, pp_ff, pp_in;
   logic [NW-1:0]      visit_ff, visit_in, comp_ff, comp_in;
   logic [NW-1:0]      qn_ff, qn_in;
   logic               qok_ff, qok_in;
   logic [FIELD_W-1:0] ans_ff, ans_in;

   logic [NW-1:0]      sp_m1, sp_m2, pp_m1;
   logic               accept;
   logic [31:0]        ea32, eb32;
   logic [AW:0]        tot_p2;

   // store ports
   logic               list_we;
   logic [NW-1:0]      list_waddr, list_raddr;
   logic [2*AW-1:0]    list_wdata, list_rdata;
   logic               tgt_we;
   logic [ARW-1:0]     tgt_waddr, tgt_raddr;
   logic [NW-1:0]      tgt_wdata, tgt_rdata;
   logic               nxt_we;
   logic [ARW-1:0]     nxt_waddr, nxt_raddr;
   logic [AW-1:0]      nxt_wdata, nxt_rdata;
   logic               disc_we;
   logic [NW-1:0]      disc_waddr, disc_raddr, disc_wdata, disc_rdata;
   logic               lab_we;
   logic [NW-1:0]      lab_waddr, lab_raddr, lab_wdata, lab_rdata;
   logic               stk_we;
   logic [STW-1:0]     stk_waddr, stk_raddr;
   frame_type          stk_wdata, stk_rdata;
   logic               pend_we;
   logic [STW-1:0]     pend_waddr, pend_raddr;
   logic [NW-1:0]      pend_wdata, pend_rdata;

   tecc_ram #(.WIDTH(2*AW), .DEPTH(MAX_NODES+1)) u_list (
      .clock(clock), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
      .raddr(list_raddr), .rdata(list_rdata));
   tecc_ram #(.WIDTH(NW), .DEPTH(ARC_CAP)) u_tgt (
      .clock(clock), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
      .raddr(tgt_raddr), .rdata(tgt_rdata));
   tecc_ram #(.WIDTH(AW), .DEPTH(ARC_CAP)) u_nxt (
      .clock(clock), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
      .raddr(nxt_raddr), .rdata(nxt_rdata));
   tecc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES+1)) u_disc (
      .clock(clock), .we(disc_we), .waddr(disc_waddr), .wdata(disc_wdata),
      .raddr(disc_raddr), .rdata(disc_rdata));
   tecc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES+1)) u_lab (
      .clock(clock), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
      .raddr(lab_raddr), .rdata(lab_rdata));
   tecc_ram #(.WIDTH(FRW), .DEPTH(MAX_NODES)) u_stk (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_rdata));
   tecc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_pend (
      .clock(clock), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
      .raddr(pend_raddr), .rdata(pend_rdata));

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign sp_m1     = sp_ff - NW'(1);
   assign sp_m2     = sp_ff - NW'(2);
   assign pp_m1     = pp_ff - NW'(1);
   assign ea32      = 32'(req_end_a);
   assign eb32      = 32'(req_end_b);
   assign tot_p2    = {1'b0, tot_ff} + (AW+1)'(2);

   assign rsp_load.valid    = (state_ff == S_RESP) && rsp_free;
   assign rsp_load.answer   = ans_ff;
   assign rsp_load.overflow = ovf_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      tot_in    = tot_ff;
      ovf_in    = ovf_ff;
      boot_in   = boot_ff;
      from_in   = from_ff;
      to_in     = to_ff;
      second_in = second_ff;
      tail_in   = tail_ff;
      link_in   = link_ff;
      x_in      = x_ff;
      par_in    = par_ff;
      arc_in    = arc_ff;
      xdisc_in  = xdisc_ff;
      xlow_in   = xlow_ff;
      nt_in     = nt_ff;
      np_in     = np_ff;
      t_in      = t_ff;
      sp_in     = sp_ff;
      pp_in     = pp_ff;
      visit_in  = visit_ff;
      comp_in   = comp_ff;
      qn_in     = qn_ff;
      qok_in    = qok_ff;
      ans_in    = ans_ff;

      list_we    = 1'b0;
      list_waddr = cnt_ff;
      list_wdata = {NO_ARC, NO_ARC};
      list_raddr = from_ff;
      tgt_we     = 1'b0;
      tgt_waddr  = tot_ff[ARW-1:0];
      tgt_wdata  = to_ff;
      tgt_raddr  = arc_ff[ARW-1:0];
      nxt_we     = 1'b0;
      nxt_waddr  = tot_ff[ARW-1:0];
      nxt_wdata  = NO_ARC;
      nxt_raddr  = arc_ff[ARW-1:0];
      disc_we    = 1'b0;
      disc_waddr = cnt_ff;
      disc_wdata = '0;
      disc_raddr = t_ff;
      lab_we     = 1'b0;
      lab_waddr  = cnt_ff;
      lab_wdata  = '0;
      lab_raddr  = qn_ff;
      stk_we     = 1'b0;
      stk_waddr  = sp_m1[STW-1:0];
      stk_wdata  = '{node: x_ff, parent: par_ff, arc: arc_ff, disc: xdisc_ff, low: xlow_ff};
      stk_raddr  = sp_m2[STW-1:0];
      pend_we    = 1'b0;
      pend_waddr = pp_ff[STW-1:0];
      pend_wdata = t_ff;
      pend_raddr = pp_m1[STW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (action_type'(req_action))
                  ACT_ADD: begin
                     if (ea32 != 0 && eb32 != 0 && ea32 <= 32'(MAX_NODES) &&
                         eb32 <= 32'(MAX_NODES)) begin
                        if (tot_p2 > (AW+1)'(ARC_CAP)) begin
                           ovf_in = 1'b1;
                        end else begin
                           from_in   = NW'(req_end_a);
                           to_in     = NW'(req_end_b);
                           second_in = 1'b0;
                           state_in  = S_ADD_RD;
                        end
                     end
                  end
                  ACT_RUN: begin
                     cnt_in   = '0;
                     state_in = S_NCLR;
                  end
                  ACT_QUERY: begin
                     qn_in    = NW'(req_end_a);
                     qok_in   = (ea32 >= 1) && (ea32 <= 32'(eff_nodes));
                     state_in = S_QRY;
                  end
                  ACT_CLEAR: begin
                     cnt_in   = '0;
                     tot_in   = '0;
                     ovf_in   = 1'b0;
                     state_in = S_LCLR;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LCLR: begin
            list_we = 1'b1;
            // after reset, zero the labels as well
            lab_we  = boot_ff;
            cnt_in  = cnt_ff + NW'(1);
            if (cnt_ff == LAST_NODE) begin
               boot_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_ADD_RD: begin
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            tgt_we     = 1'b1;
            nxt_we     = 1'b1;
            list_we    = 1'b1;
            list_waddr = from_ff;
            link_in    = (list_rdata[2*AW-1:AW] != NO_ARC);
            tail_in    = list_rdata[AW-1:0];
            list_wdata = (list_rdata[2*AW-1:AW] == NO_ARC) ? {tot_ff, tot_ff}
                                                            : {list_rdata[2*AW-1:AW], tot_ff};
            state_in   = S_ADD_LINK;
         end
         S_ADD_LINK: begin
            // chain the new arc behind the old tail
            nxt_we    = link_ff;
            nxt_waddr = tail_ff[ARW-1:0];
            nxt_wdata = tot_ff;
            tot_in    = tot_ff + AW'(1);
            if (!second_ff) begin
               from_in   = to_ff;
               to_in     = from_ff;
               second_in = 1'b1;
               state_in  = S_ADD_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_NCLR: begin
            disc_we = 1'b1;
            lab_we  = 1'b1;
            cnt_in  = cnt_ff + NW'(1);
            if (cnt_ff == LAST_NODE) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            disc_we    = 1'b1;
            disc_waddr = NW'(1);
            disc_wdata = NW'(1);
            pend_we    = 1'b1;
            pend_waddr = '0;
            pend_wdata = NW'(1);
            list_raddr = NW'(1);
            pp_in      = NW'(1);
            sp_in      = '0;
            visit_in   = NW'(1);
            comp_in    = '0;
            nt_in      = NW'(1);
            np_in      = '0;
            state_in   = S_PUSH_H;
         end
         S_PUSH_H: begin
            x_in     = nt_ff;
            par_in   = np_ff;
            arc_in   = list_rdata[2*AW-1:AW];
            xdisc_in = visit_ff;
            xlow_in  = visit_ff;
            sp_in    = sp_ff + NW'(1);
            state_in = S_ARC;
         end
         S_ARC: begin
            state_in = (arc_ff < NO_ARC) ? S_ARC_W : S_FIN;
         end
         S_ARC_W: begin
            arc_in = nxt_rdata;
            t_in   = tgt_rdata;
            // drop arcs to the parent, to node zero and beyond the node count
            if (tgt_rdata == par_ff || tgt_rdata == '0 || tgt_rdata > eff_nodes) begin
               state_in = S_ARC;
            end else begin
               disc_raddr = tgt_rdata;
               state_in   = S_ARC_N;
            end
         end
         S_ARC_N: begin
            if (disc_rdata == '0) begin
               stk_we     = 1'b1;
               disc_we    = 1'b1;
               disc_waddr = t_ff;
               disc_wdata = visit_ff + NW'(1);
               pend_we    = 1'b1;
               pp_in      = pp_ff + NW'(1);
               visit_in   = visit_ff + NW'(1);
               list_raddr = t_ff;
               nt_in      = t_ff;
               np_in      = x_ff;
               state_in   = S_PUSH_H;
            end else begin
               if (disc_rdata < xlow_ff) begin
                  xlow_in = disc_rdata;
               end
               state_in = S_ARC;
            end
         end
         S_FIN: begin
            if (xdisc_ff == xlow_ff) begin
               comp_in  = comp_ff + NW'(1);
               state_in = S_POP_RD;
            end else begin
               state_in = S_RET;
            end
         end
         S_POP_RD: begin
            if (pp_ff == '0) begin
               state_in = S_RET;
            end else begin
               pp_in    = pp_m1;
               state_in = S_POP_W;
            end
         end
         S_POP_W: begin
            lab_we    = 1'b1;
            lab_waddr = pend_rdata;
            lab_wdata = comp_ff;
            state_in  = (pend_rdata == x_ff) ? S_RET : S_POP_RD;
         end
         S_RET: begin
            sp_in = sp_m1;
            if (sp_ff == NW'(1)) begin
               ans_in   = FIELD_W'(comp_ff);
               state_in = S_RESP;
            end else begin
               state_in = S_RET_W;
            end
         end
         S_RET_W: begin
            // restore the parent frame and fold in the child's low-link
            x_in     = stk_rdata.node;
            par_in   = stk_rdata.parent;
            arc_in   = stk_rdata.arc;
            xdisc_in = stk_rdata.disc;
            xlow_in  = (xlow_ff < stk_rdata.low) ? xlow_ff : stk_rdata.low;
            state_in = S_ARC;
         end
         S_QRY: begin
            state_in = S_QRY_W;
         end
         S_QRY_W: begin
            ans_in   = qok_ff ? FIELD_W'(lab_rdata) : '0;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LCLR;
         cnt_ff   <= '0;
         tot_ff   <= '0;
         ovf_ff   <= 1'b0;
         boot_ff  <= 1'b1;
         sp_ff    <= '0;
         pp_ff    <= '0;
         visit_ff <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         tot_ff   <= tot_in;
         ovf_ff   <= ovf_in;
         boot_ff  <= boot_in;
         sp_ff    <= sp_in;
         pp_ff    <= pp_in;
         visit_ff <= visit_in;
         comp_ff  <= comp_in;
      end
   end

   always_ff @(posedge clock) begin
      from_ff   <= from_in;
      to_ff     <= to_in;
      second_ff <= second_in;
      tail_ff   <= tail_in;
      link_ff   <= link_in;
      x_ff      <= x_in;
      par_ff    <= par_in;
      arc_ff    <= arc_in;
      xdisc_ff  <= xdisc_in;
      xlow_ff   <= xlow_in;
      nt_ff     <= nt_in;
      np_ff     <= np_in;
      t_ff      <= t_in;
      qn_ff     <= qn_in;
      qok_ff    <= qok_in;
      ans_ff    <= ans_in;
   end

   `TECC_ASSERT_IMP(a_frame_live, clock, reset, (state_ff == S_ARC) || (state_ff == S_FIN), sp_ff != '0)
   `TECC_ASSERT_IMP(a_low_bound, clock, reset, state_ff == S_ARC, xlow_ff <= xdisc_ff)
   `TECC_ASSERT_IMP(a_arc_cap, clock, reset, state_ff == S_IDLE, tot_ff <= NO_ARC)
   `TECC_ASSERT_NXT(a_resp_done, clock, reset, rsp_load.valid, state_ff == S_IDLE)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Checks the bridge-free component labeller against a behavioural Tarjan
// search: edge loads, labelling runs, label queries and graph clears, with
// random idle gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module tb_top;
   import tecc_pkg::*;

   localparam int NODES    = DEF_MAX_NODES;
   localparam int ARCS     = 2 * DEF_MAX_EDGES;
   localparam int NO_LINK  = ARCS;
   localparam int SETTLE   = 1200;
   localparam int MAX_CYC  = 3000000;

   typedef struct {
      action_type       act;
      logic [FIELD_W-1:0] end_a;
      logic [FIELD_W-1:0] end_b;
   } request_type;

   typedef struct {
      logic [FIELD_W-1:0] answer;
      logic               overflow;
   } label_result_type;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [FIELD_W-1:0] csr_wr_data;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_action;
   logic [FIELD_W-1:0] req_end_a;
   logic [FIELD_W-1:0] req_end_b;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [FIELD_W-1:0] rsp_answer;
   logic               rsp_overflow;

   request_type      pending_req[$];
   label_result_type expected_labels[$];
   int            mismatches;
   int            cycles;
   int            send_gap;
   int            recv_gap;
   int            recv_hold;
   bit            no_gaps;
   bit            req_taken;

   // behavioural copy of the graph and the search
   int cfg_nodes;
   int arc_dst[ARCS];
   int arc_link[ARCS];
   int head[NODES+1];
   int tail[NODES+1];
   int arc_used;
   int disc[NODES+1];
   int lowl[NODES+1];
   int label[NODES+1];
   int comp_total;
   bit ovf;

   two_edge_connected_component_label_top i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_end_a    (req_end_a),
      .req_end_b    (req_end_b),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_answer   (rsp_answer),
      .rsp_overflow (rsp_overflow)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int active_nodes();
      if (cfg_nodes < 1) return 1;
      if (cfg_nodes > NODES) return NODES;
      return cfg_nodes;
   endfunction

   function automatic void graph_clear();
      for (int i = 0; i <= NODES; i++) begin
         head[i] = NO_LINK;
         tail[i] = NO_LINK;
      end
      arc_used = 0;
      ovf = 1'b0;
   endfunction

   function automatic void graph_append(int from, int to);
      arc_dst[arc_used] = to;
      arc_link[arc_used] = NO_LINK;
      if (head[from] == NO_LINK) head[from] = arc_used;
      else arc_link[tail[from]] = arc_used;
      tail[from] = arc_used;
      arc_used++;
   endfunction

   function automatic void graph_add(int a, int b);
      if (a == 0 || b == 0 || a > NODES || b > NODES) return;
      if (arc_used + 2 > ARCS) begin
         ovf = 1'b1;
         return;
      end
      graph_append(a, b);
      graph_append(b, a);
   endfunction

   // iterative Tarjan search from node 1, bridge-free components
   function automatic void label_components();
      int n, sp, pp, visits, x, par, a, t, y, p;
      int stk_node[NODES+1];
      int stk_par[NODES+1];
      int stk_arc[NODES+1];
      int open_nodes[NODES+1];
      n = active_nodes();
      for (int i = 0; i <= NODES; i++) begin
         disc[i] = 0;
         lowl[i] = 0;
         label[i] = 0;
      end
      comp_total = 0;
      visits = 1;
      disc[1] = 1;
      lowl[1] = 1;
      open_nodes[0] = 1;
      pp = 1;
      stk_node[0] = 1;
      stk_par[0] = 0;
      stk_arc[0] = head[1];
      sp = 1;
      while (sp > 0) begin
         x = stk_node[sp-1];
         par = stk_par[sp-1];
         a = stk_arc[sp-1];
         if (a < ARCS) begin
            t = arc_dst[a];
            stk_arc[sp-1] = arc_link[a];
            if (t == par || t == 0 || t > n) continue;
            if (disc[t] == 0) begin
               visits++;
               disc[t] = visits;
               lowl[t] = visits;
               open_nodes[pp++] = t;
               stk_node[sp] = t;
               stk_par[sp] = x;
               stk_arc[sp] = head[t];
               sp++;
            end else if (disc[t] < lowl[x]) begin
               lowl[x] = disc[t];
            end
         end else begin
            if (disc[x] == lowl[x]) begin
               comp_total++;
               while (pp > 0) begin
                  pp--;
                  y = open_nodes[pp];
                  label[y] = comp_total;
                  if (y == x) break;
               end
            end
            sp--;
            if (sp > 0) begin
               p = stk_node[sp-1];
               if (lowl[x] < lowl[p]) lowl[p] = lowl[x];
            end
         end
      end
   endfunction

   function automatic void predict_request(request_type r);
      label_result_type res;
      case (r.act)
         ACT_ADD: graph_add(r.end_a, r.end_b);
         ACT_CLEAR: graph_clear();
         ACT_RUN: begin
            label_components();
            res.answer = comp_total[FIELD_W-1:0];
            res.overflow = ovf;
            expected_labels.insert(expected_labels.size(), res);
         end
         default: begin
            res.answer = (r.end_a >= 1 && r.end_a <= active_nodes()) ?
                         label[r.end_a][FIELD_W-1:0] : '0;
            res.overflow = ovf;
            expected_labels.insert(expected_labels.size(), res);
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
      mismatches++;
   endtask

   // request side: accept at the rising edge, drive at the falling edge
   always @(posedge clock) begin
      req_taken <= 1'b0;
      if (!reset && req_valid && !req_stall) begin
         request_type r;
         r.act = action_type'(req_action);
         r.end_a = req_end_a;
         r.end_b = req_end_b;
         predict_request(r);
         req_taken <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_req.size() > 0) begin
            request_type r;
            r = pending_req.pop_front();
            req_action <= r.act;
            req_end_a <= r.end_a;
            req_end_b <= r.end_b;
            req_valid <= 1'b1;
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side
   always @(negedge clock) begin
      if (recv_hold > 0) begin
         rsp_stall <= 1'b1;
         recv_hold <= recv_hold - 1;
      end else if (recv_gap > 0) begin
         rsp_stall <= 1'b1;
         recv_gap <= recv_gap - 1;
      end else begin
         rsp_stall <= 1'b0;
         recv_gap <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_labels.size() == 0) begin
            report_mismatch("unexpected response", rsp_answer, -1);
         end else begin
            label_result_type e;
            e = expected_labels.pop_front();
            if (rsp_answer !== e.answer) report_mismatch("answer", rsp_answer, e.answer);
            if (rsp_overflow !== e.overflow)
               report_mismatch("overflow", rsp_overflow, e.overflow);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYC) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_request(action_type act, int a, int b);
      request_type r;
      r.act = act;
      r.end_a = a[FIELD_W-1:0];
      r.end_b = b[FIELD_W-1:0];
      pending_req.insert(pending_req.size(), r);
   endtask

   // hold until every request is taken and answered, then let the core settle
   task automatic wait_idle();
      while (pending_req.size() > 0 || req_valid || expected_labels.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_node_count(int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[FIELD_W-1:0];
      cfg_nodes = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int pick_end(int span);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return 0;
      if (r < 8) return $urandom_range(1, 2047);
      return $urandom_range(1, span);
   endfunction

   // an optional clear, a small random graph, an optional query, a run and a few queries
   task automatic push_graph_sequence();
      int span, edges, queries;
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 1024) : $urandom_range(2, 12);
      if ($urandom_range(0, 4) != 0) push_request(ACT_CLEAR, $urandom, $urandom);
      edges = $urandom_range(0, 16);
      for (int i = 0; i < edges; i++)
         push_request(ACT_ADD, pick_end(span), pick_end(span));
      if ($urandom_range(0, 5) == 0)
         push_request(ACT_QUERY, pick_end(span), $urandom);
      push_request(ACT_RUN, $urandom, $urandom);
      queries = $urandom_range(1, 8);
      for (int i = 0; i < queries; i++)
         push_request(ACT_QUERY, pick_end(span + 2), $urandom);
   endtask

   initial begin
      int settings[8];
      int sent;
      settings = '{5, 1, 1024, 0, 2047, 12, 3, 700};
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_action = ACT_ADD;
      req_end_a = '0;
      req_end_b = '0;
      rsp_stall = 1'b0;
      send_gap = 0;
      recv_gap = 0;
      recv_hold = 0;
      no_gaps = 1'b0;
      mismatches = 0;
      cycles = 0;
      cfg_nodes = 1;
      graph_clear();
      label_components();
      for (int i = 0; i <= NODES; i++) label[i] = 0;
      comp_total = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: triangle, bridge, self loop, parallel edges, bad ends
      write_node_count(5);
      push_request(ACT_QUERY, 1, 0);
      push_request(ACT_ADD, 1, 2);
      push_request(ACT_ADD, 2, 3);
      push_request(ACT_ADD, 3, 1);
      push_request(ACT_ADD, 3, 4);
      push_request(ACT_ADD, 4, 4);
      push_request(ACT_ADD, 4, 5);
      push_request(ACT_ADD, 5, 4);
      push_request(ACT_ADD, 0, 3);
      push_request(ACT_ADD, 1025, 2);
      push_request(ACT_ADD, 2047, 2047);
      push_request(ACT_ADD, 5, 6);
      push_request(ACT_RUN, 2047, 2047);
      push_request(ACT_QUERY, 0, 2047);
      push_request(ACT_QUERY, 1, 0);
      push_request(ACT_QUERY, 4, 0);
      push_request(ACT_QUERY, 5, 0);
      push_request(ACT_QUERY, 6, 0);
      push_request(ACT_QUERY, 2047, 0);
      push_request(ACT_CLEAR, 0, 0);
      push_request(ACT_QUERY, 3, 0);
      push_request(ACT_RUN, 0, 0);
      wait_idle();

      // random phases over several node counts
      for (int ph = 0; ph < 8; ph++) begin
         write_node_count(settings[ph]);
         no_gaps = (ph == 2);
         if (ph == 4) recv_hold = 600;
         sent = 0;
         while (sent < 200) begin
            int before_len;
            before_len = pending_req.size();
            push_graph_sequence();
            sent += pending_req.size() - before_len;
         end
         wait_idle();
      end
      no_gaps = 1'b0;

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
